// ===== rtl/mpsm_pkg.sv =====
// Shared types and codes of the multi-pattern symbol matcher.
`default_nettype none
package mpsm_pkg;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_BUILD  = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_TOO_LONG  = 2'd2;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd3;

   localparam int MAX_RESULTS = 32;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] symbol;
      logic        end_of_pattern;
      logic        start_of_text;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        match_valid;
      logic [31:0] match_start;
      logic [31:0] match_end;
      logic [9:0]  match_node;
      logic        last_result;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/mpsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module mpsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/multi_pattern_symbol_matcher.sv =====
// Top level of the multi-pattern symbol matcher: trie store, link builder and search sequencer.
//
// A command word is taken on req_data at a rising edge where start is high and busy is low.
// Action add puts one pattern symbol into the trie, build computes failure and output links,
// search steps the automaton by one text symbol. Every command gives one or more response
// words on rsp_data, each shown for one cycle with rsp_valid high; last_result marks the
// final word of the command. The receiver cannot stall: words must be taken as they come.
// All node data sits in one RAM with a registered read, and one compare unit walks it, so
// every child lookup scans nodes 1 to node_count in turn and stops at the first match.
// An add reads the cursor node and does at most one child lookup; a pattern end adds a read
// and a write that marks it. A search takes up to MAX_DEPTH+2 lookups along the failure
// chain, then reports up to MAX_RESULTS matches. A build sweeps all nodes for each of
// MAX_DEPTH levels, up to MAX_DEPTH+2 lookups a node. busy stays high for the whole command.
// Reset empties the trie (root only), clears the insert cursor, the search state, the text
// position and the built flag; no clearing pass over the RAM is needed.
`default_nettype none
module multi_pattern_symbol_matcher
   import mpsm_pkg::*;
#(
   parameter int MAX_NODES     = 1024,
   parameter int MAX_DEPTH     = 32,
   parameter int SYMBOL_BITS   = 16,
   parameter int POSITION_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int SW = $clog2(MAX_DEPTH + 2);
   localparam int KW = $clog2(MAX_RESULTS);
   localparam int PB = POSITION_BITS;
   localparam int SB = SYMBOL_BITS;
   localparam logic [SW-1:0] STEP_LIMIT = SW'(MAX_DEPTH + 1);

   typedef struct packed {
      logic [AW-1:0] parent;
      logic [SB-1:0] symbol;
      logic [DW-1:0] depth;
      logic          is_end;
      logic [AW-1:0] fail;
      logic [AW-1:0] out_link;
   } node_rec_type;

   typedef enum logic [4:0] {
      IDLE, RD_WAIT, CS_START, CS_WAIT, CS_CMP,
      ADD_DEPTH, ADD_CHILD, ADD_EOP, ADD_MARK,
      B_RDN, B_CHK, B_PAR, B_SCAN, B_SCANR, B_FOLLOW, B_RDFL, B_WR, B_NEXT,
      S_SCAN, S_SCANR, S_FOLLOW, S_POS, S_M0, S_MLOOP, S_MEMIT
   } state_type;

   state_type     state_ff, state_in, ret_ff, ret_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic [AW-1:0] node_count_ff, node_count_in;
   logic [AW-1:0] cursor_ff, cursor_in;
   logic          discard_ff, discard_in;
   logic          built_ff, built_in;
   logic [AW-1:0] mstate_ff, mstate_in;
   logic [PB-1:0] pos_ff, pos_in;
   req_type       req_ff, req_in;
   logic [1:0]    status_ff, status_in;
   logic [DW-1:0] nd_ff, nd_in;
   logic [AW-1:0] scan_p_ff, scan_p_in;
   logic [SB-1:0] scan_sym_ff, scan_sym_in;
   logic          found_ff, found_in;
   logic [AW-1:0] child_ff, child_in;
   logic [DW-1:0] d_ff, d_in;
   logic [AW-1:0] n_ff, n_in;
   node_rec_type  cur_rec_ff, cur_rec_in;
   logic [AW-1:0] f_ff, f_in;
   logic [AW-1:0] fl_ff, fl_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [AW-1:0] m_ff, m_in;
   logic [KW-1:0] k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   node_rec_type  wr_rec;
   node_rec_type  ram_rd;
   node_rec_type  rec;

   logic [SB+15:0] sym_wide;
   logic [SB-1:0]  sym_w;
   logic [PB+31:0] pos_wide;
   logic [PB-1:0]  start_pos;
   logic [PB+31:0] start_wide;
   logic [AW+9:0]  node_wide;
   logic [DW:0]    nd_sum;
   logic [AW:0]    count_next;

   mpsm_ram #(
      .WIDTH($bits(node_rec_type)),
      .DEPTH(MAX_NODES)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_rec),
      .rd_addr(raddr_ff),
      .rd_data(ram_rd)
   );

   // The root is never written; it reads as all zeros.
   assign rec = (raddr_ff == '0) ? '0 : ram_rd;

   assign sym_wide   = {{SB{1'b0}}, req_ff.symbol};
   assign sym_w      = sym_wide[SB-1:0];
   assign pos_wide   = {32'b0, pos_ff};
   assign start_pos  = pos_ff - PB'(rec.depth);
   assign start_wide = {32'b0, start_pos};
   assign node_wide  = {10'b0, m_ff};
   assign nd_sum     = {1'b0, rec.depth} + (DW + 1)'(1);
   assign count_next = {1'b0, node_count_ff} + (AW + 1)'(1);

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      raddr_in      = raddr_ff;
      node_count_in = node_count_ff;
      cursor_in     = cursor_ff;
      discard_in    = discard_ff;
      built_in      = built_ff;
      mstate_in     = mstate_ff;
      pos_in        = pos_ff;
      req_in        = req_ff;
      status_in     = status_ff;
      nd_in         = nd_ff;
      scan_p_in     = scan_p_ff;
      scan_sym_in   = scan_sym_ff;
      found_in      = found_ff;
      child_in      = child_ff;
      d_in          = d_ff;
      n_in          = n_ff;
      cur_rec_in    = cur_rec_ff;
      f_in          = f_ff;
      fl_in         = fl_ff;
      steps_in      = steps_ff;
      m_in          = m_ff;
      k_in          = k_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = n_ff;
      wr_rec        = cur_rec_ff;

      case (state_ff)
         IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.action)
                  ACT_ADD: begin
                     built_in  = 1'b0;
                     status_in = STAT_OK;
                     if (discard_ff) begin
                        state_in = ADD_EOP;
                     end else begin
                        raddr_in = cursor_ff;
                        ret_in   = ADD_DEPTH;
                        state_in = RD_WAIT;
                     end
                  end
                  ACT_BUILD: begin
                     if (node_count_ff == '0) begin
                        built_in     = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{STAT_OK, 1'b0, 32'd0, 32'd0, 10'd0, 1'b1};
                     end else begin
                        d_in     = DW'(1);
                        n_in     = AW'(1);
                        state_in = B_RDN;
                     end
                  end
                  ACT_SEARCH: begin
                     if (req_data.start_of_text) begin
                        mstate_in = '0;
                        pos_in    = '0;
                     end
                     if (!built_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{STAT_NOT_BUILT, 1'b0, 32'd0, 32'd0, 10'd0, 1'b1};
                     end else begin
                        steps_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{STAT_OK, 1'b0, 32'd0, 32'd0, 10'd0, 1'b1};
                  end
               endcase
            end
         end

         RD_WAIT: state_in = ret_ff;

         // Child lookup: scan nodes 1 to node_count for a matching parent and symbol.
         CS_START: begin
            if (node_count_ff == '0) begin
               found_in = 1'b0;
               state_in = ret_ff;
            end else begin
               raddr_in = AW'(1);
               state_in = CS_WAIT;
            end
         end
         CS_WAIT: state_in = CS_CMP;
         CS_CMP: begin
            if (rec.parent == scan_p_ff && rec.symbol == scan_sym_ff) begin
               found_in = 1'b1;
               child_in = raddr_ff;
               state_in = ret_ff;
            end else if (raddr_ff == node_count_ff) begin
               found_in = 1'b0;
               state_in = ret_ff;
            end else begin
               raddr_in = raddr_ff + AW'(1);
               state_in = CS_WAIT;
            end
         end

         ADD_DEPTH: begin
            if (nd_sum > (DW + 1)'(MAX_DEPTH)) begin
               status_in  = STAT_TOO_LONG;
               discard_in = 1'b1;
               state_in   = ADD_EOP;
            end else begin
               nd_in       = nd_sum[DW-1:0];
               scan_p_in   = cursor_ff;
               scan_sym_in = sym_w;
               ret_in      = ADD_CHILD;
               state_in    = CS_START;
            end
         end
         ADD_CHILD: begin
            state_in = ADD_EOP;
            if (found_ff) begin
               cursor_in = child_ff;
            end else if (count_next >= (AW + 1)'(MAX_NODES)) begin
               status_in  = STAT_FULL;
               discard_in = 1'b1;
            end else begin
               node_count_in = count_next[AW-1:0];
               cursor_in     = count_next[AW-1:0];
               wr_en         = 1'b1;
               wr_addr       = count_next[AW-1:0];
               wr_rec        = '{cursor_ff, sym_w, nd_ff, 1'b0, {AW{1'b0}}, {AW{1'b0}}};
            end
         end
         ADD_EOP: begin
            if (req_ff.end_of_pattern && !discard_ff && cursor_ff != '0) begin
               raddr_in = cursor_ff;
               ret_in   = ADD_MARK;
               state_in = RD_WAIT;
            end else begin
               if (req_ff.end_of_pattern) begin
                  cursor_in  = '0;
                  discard_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_in       = '{status_ff, 1'b0, 32'd0, 32'd0, 10'd0, 1'b1};
               state_in     = IDLE;
            end
         end
         ADD_MARK: begin
            wr_en         = 1'b1;
            wr_addr       = raddr_ff;
            wr_rec        = rec;
            wr_rec.is_end = 1'b1;
            cursor_in     = '0;
            discard_in    = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_in        = '{status_ff, 1'b0, 32'd0, 32'd0, 10'd0, 1'b1};
            state_in      = IDLE;
         end

         // Link build: one sweep over the nodes for each level.
         B_RDN: begin
            raddr_in = n_ff;
            ret_in   = B_CHK;
            state_in = RD_WAIT;
         end
         B_CHK: begin
            cur_rec_in = rec;
            if (rec.depth != d_ff) begin
               state_in = B_NEXT;
            end else if (d_ff == DW'(1)) begin
               fl_in    = '0;
               state_in = B_RDFL;
            end else begin
               raddr_in = rec.parent;
               ret_in   = B_PAR;
               state_in = RD_WAIT;
            end
         end
         B_PAR: begin
            f_in     = rec.fail;
            steps_in = '0;
            state_in = B_SCAN;
         end
         B_SCAN: begin
            scan_p_in   = f_ff;
            scan_sym_in = cur_rec_ff.symbol;
            ret_in      = B_SCANR;
            state_in    = CS_START;
         end
         B_SCANR: begin
            if (found_ff) begin
               fl_in    = child_ff;
               state_in = B_RDFL;
            end else if (f_ff == '0 || steps_ff == STEP_LIMIT) begin
               fl_in    = '0;
               state_in = B_RDFL;
            end else begin
               raddr_in = f_ff;
               ret_in   = B_FOLLOW;
               state_in = RD_WAIT;
            end
         end
         B_FOLLOW: begin
            f_in     = rec.fail;
            steps_in = steps_ff + SW'(1);
            state_in = B_SCAN;
         end
         B_RDFL: begin
            raddr_in = fl_ff;
            ret_in   = B_WR;
            state_in = RD_WAIT;
         end
         B_WR: begin
            wr_en           = 1'b1;
            wr_addr         = n_ff;
            wr_rec          = cur_rec_ff;
            wr_rec.fail     = fl_ff;
            wr_rec.out_link = rec.is_end ? fl_ff : rec.out_link;
            state_in        = B_NEXT;
         end
         B_NEXT: begin
            if (n_ff == node_count_ff) begin
               if (d_ff == DW'(MAX_DEPTH)) begin
                  built_in     = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{STAT_OK, 1'b0, 32'd0, 32'd0, 10'd0, 1'b1};
                  state_in     = IDLE;
               end else begin
                  d_in     = d_ff + DW'(1);
                  n_in     = AW'(1);
                  state_in = B_RDN;
               end
            end else begin
               n_in     = n_ff + AW'(1);
               state_in = B_RDN;
            end
         end

         // Search: walk the failure chain, then report along the output links.
         S_SCAN: begin
            scan_p_in   = mstate_ff;
            scan_sym_in = sym_w;
            ret_in      = S_SCANR;
            state_in    = CS_START;
         end
         S_SCANR: begin
            if (found_ff) begin
               mstate_in = child_ff;
               state_in  = S_POS;
            end else if (mstate_ff == '0) begin
               state_in = S_POS;
            end else begin
               raddr_in = mstate_ff;
               ret_in   = S_FOLLOW;
               state_in = RD_WAIT;
            end
         end
         S_FOLLOW: begin
            mstate_in = rec.fail;
            if (steps_ff == STEP_LIMIT) begin
               state_in = S_POS;
            end else begin
               steps_in = steps_ff + SW'(1);
               state_in = S_SCAN;
            end
         end
         S_POS: begin
            pos_in   = pos_ff + PB'(1);
            raddr_in = mstate_ff;
            ret_in   = S_M0;
            state_in = RD_WAIT;
         end
         S_M0: begin
            m_in     = rec.is_end ? mstate_ff : rec.out_link;
            k_in     = '0;
            state_in = S_MLOOP;
         end
         S_MLOOP: begin
            if (m_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{STAT_OK, 1'b0, 32'd0, 32'd0, 10'd0, 1'b1};
               state_in     = IDLE;
            end else begin
               raddr_in = m_ff;
               ret_in   = S_MEMIT;
               state_in = RD_WAIT;
            end
         end
         S_MEMIT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STAT_OK;
            rsp_in.match_valid = 1'b1;
            rsp_in.match_start = start_wide[31:0];
            rsp_in.match_end   = pos_wide[31:0];
            rsp_in.match_node  = node_wide[9:0];
            if (rec.out_link == '0 || k_ff == KW'(MAX_RESULTS - 1)) begin
               rsp_in.last_result = 1'b1;
               state_in           = IDLE;
            end else begin
               rsp_in.last_result = 1'b0;
               m_in               = rec.out_link;
               k_in               = k_ff + KW'(1);
               state_in           = S_MLOOP;
            end
         end

         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         node_count_ff <= '0;
         cursor_ff     <= '0;
         discard_ff    <= 1'b0;
         built_ff      <= 1'b0;
         mstate_ff     <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         cursor_ff     <= cursor_in;
         discard_ff    <= discard_in;
         built_ff      <= built_in;
         mstate_ff     <= mstate_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ret_ff      <= ret_in;
      raddr_ff    <= raddr_in;
      req_ff      <= req_in;
      status_ff   <= status_in;
      nd_ff       <= nd_in;
      scan_p_ff   <= scan_p_in;
      scan_sym_ff <= scan_sym_in;
      found_ff    <= found_in;
      child_ff    <= child_in;
      d_ff        <= d_in;
      n_ff        <= n_in;
      cur_rec_ff  <= cur_rec_in;
      f_ff        <= f_in;
      fl_ff       <= fl_in;
      steps_ff    <= steps_in;
      m_ff        <= m_in;
      k_ff        <= k_in;
      rsp_ff      <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== tb/mpsm_checker.sv =====
// Checker of the multi-pattern symbol matcher: watches both channels, predicts and compares.
module mpsm_checker
   import mpsm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           failures,
   output int           pending,
   output int           nodes
);

   localparam int NODE_LIMIT = 1024;
   localparam int DEPTH_LIMIT = 32;
   localparam int QUEUE_DEPTH = 256;

   logic [9:0]  trie_parent [NODE_LIMIT];
   logic [15:0] trie_symbol [NODE_LIMIT];
   int          trie_depth  [NODE_LIMIT];
   bit          trie_end    [NODE_LIMIT];
   logic [9:0]  trie_fail   [NODE_LIMIT];
   logic [9:0]  trie_out    [NODE_LIMIT];
   int          node_total;
   int          cursor;
   bit          discarding;
   bit          links_ready;
   int          scan_node;
   logic [31:0] text_pos;

   // Expected words wait in a ring; the counters only grow until reset clears them.
   rsp_type expected_words[QUEUE_DEPTH];
   int      wr_count;
   int      rd_count;

   function automatic int child_node(input int parent, input logic [15:0] sym);
      for (int n = 1; n <= node_total && n < NODE_LIMIT; n++)
         if (trie_parent[n] == parent && trie_symbol[n] == sym) return n;
      return 0;
   endfunction

   task automatic push_word(input logic [1:0] status, input logic hit, input logic [31:0] first,
                            input logic [31:0] last_pos, input logic [9:0] node, input logic fin);
      rsp_type w;
      w.status = status;
      w.match_valid = hit;
      w.match_start = first;
      w.match_end = last_pos;
      w.match_node = node;
      w.last_result = fin;
      expected_words[wr_count % QUEUE_DEPTH] = w;
      wr_count++;
   endtask

   function automatic logic [1:0] add_symbol(input logic [15:0] sym, input logic eop);
      logic [1:0] status;
      int c;
      status = STAT_OK;
      links_ready = 0;
      if (!discarding) begin
         if (trie_depth[cursor] + 1 > DEPTH_LIMIT) begin
            status = STAT_TOO_LONG;
            discarding = 1;
         end else begin
            c = child_node(cursor, sym);
            if (c == 0) begin
               if (node_total + 1 >= NODE_LIMIT) begin
                  status = STAT_FULL;
                  discarding = 1;
               end else begin
                  node_total++;
                  c = node_total;
                  trie_parent[c] = cursor[9:0];
                  trie_symbol[c] = sym;
                  trie_depth[c] = trie_depth[cursor] + 1;
                  trie_end[c] = 0;
                  trie_fail[c] = '0;
                  trie_out[c] = '0;
               end
            end
            if (!discarding) cursor = c;
         end
      end
      if (eop) begin
         if (!discarding && cursor != 0) trie_end[cursor] = 1;
         cursor = 0;
         discarding = 0;
      end
      return status;
   endfunction

   function automatic void build_links();
      int f, c, fl;
      for (int d = 1; d <= DEPTH_LIMIT; d++)
         for (int n = 1; n <= node_total && n < NODE_LIMIT; n++) begin
            if (trie_depth[n] != d) continue;
            fl = 0;
            if (d > 1) begin
               f = trie_fail[trie_parent[n]];
               for (int s = 0; s <= DEPTH_LIMIT + 1; s++) begin
                  c = child_node(f, trie_symbol[n]);
                  if (c != 0) begin
                     fl = c;
                     break;
                  end
                  if (f == 0) break;
                  f = trie_fail[f];
               end
            end
            trie_fail[n] = fl[9:0];
            trie_out[n] = trie_end[fl] ? fl[9:0] : trie_out[fl];
         end
      links_ready = 1;
   endfunction

   task automatic search_symbol(input logic [15:0] sym);
      int s, c, m, k;
      int hits[DEPTH_LIMIT];
      s = scan_node;
      for (int i = 0; i <= DEPTH_LIMIT + 1; i++) begin
         c = child_node(s, sym);
         if (c != 0) begin
            s = c;
            break;
         end
         if (s == 0) break;
         s = trie_fail[s];
      end
      scan_node = s;
      text_pos = text_pos + 1;
      m = trie_end[s] ? s : trie_out[s];
      k = 0;
      while (m != 0 && k < MAX_RESULTS) begin
         hits[k] = m;
         k++;
         m = trie_out[m];
      end
      if (k == 0) push_word(STAT_OK, 0, '0, '0, '0, 1);
      for (int i = 0; i < k; i++)
         push_word(STAT_OK, 1, text_pos - 32'(trie_depth[hits[i]]), text_pos,
                   hits[i][9:0], i == k - 1);
   endtask

   task automatic predict_command(input req_type cmd);
      case (cmd.action)
         ACT_ADD: push_word(add_symbol(cmd.symbol, cmd.end_of_pattern), 0, '0, '0, '0, 1);
         ACT_BUILD: begin
            build_links();
            push_word(STAT_OK, 0, '0, '0, '0, 1);
         end
         ACT_SEARCH: begin
            if (cmd.start_of_text) begin
               scan_node = 0;
               text_pos = '0;
            end
            if (!links_ready) push_word(STAT_NOT_BUILT, 0, '0, '0, '0, 1);
            else search_symbol(cmd.symbol);
         end
         default: push_word(STAT_OK, 0, '0, '0, '0, 1);
      endcase
   endtask

   task automatic check_word(input rsp_type got);
      rsp_type want;
      if (wr_count == rd_count) begin
         failures++;
         if (failures <= 10) $display("unexpected response word %p", got);
      end else begin
         want = expected_words[rd_count % QUEUE_DEPTH];
         rd_count++;
         if (got !== want) begin
            failures++;
            if (failures <= 10) $display("mismatch: expected %p, got %p", want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NODE_LIMIT; n++) begin
            trie_parent[n] = '0;
            trie_symbol[n] = '0;
            trie_depth[n] = 0;
            trie_end[n] = 0;
            trie_fail[n] = '0;
            trie_out[n] = '0;
         end
         node_total = 0;
         cursor = 0;
         discarding = 0;
         links_ready = 0;
         scan_node = 0;
         text_pos = '0;
         failures = 0;
         wr_count = 0;
         rd_count = 0;
      end else begin
         if (rsp_valid) check_word(rsp_data);
         if (start && !busy) predict_command(req_data);
      end
      pending = wr_count - rd_count;
      nodes = node_total;
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the matcher testbench: clock, reset, command stimulus and verdict.
module testbench;
   import mpsm_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      nodes;
   bit      gaps_on = 1;
   int      sent = 0;

   multi_pattern_symbol_matcher i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   mpsm_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .failures(failures), .pending(pending), .nodes(nodes)
   );

   always #2 clock = ~clock;

   initial begin
      #100_000_000;
      $display("multi_pattern_symbol_matcher verification failed");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic issue(input logic [1:0] act, input logic [15:0] sym,
                        input logic eop, input logic sot);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      start <= 1;
      req_data <= '{action: act, symbol: sym, end_of_pattern: eop, start_of_text: sot};
      do @(posedge clock); while (busy);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] text_symbol();
      return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
   endfunction

   initial begin
      int len;
      logic [15:0] fresh;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      issue(ACT_SEARCH, 16'hFFFF, 1, 1);
      issue(2'd3, 16'hFFFF, 1, 1);
      issue(ACT_ADD, 16'd1, 0, 1);
      issue(ACT_ADD, 16'd2, 1, 0);
      issue(ACT_ADD, 16'd2, 1, 0);
      issue(ACT_ADD, 16'hFFFF, 1, 0);
      issue(ACT_ADD, 16'd2, 0, 0);
      issue(ACT_ADD, 16'd1, 0, 0);
      issue(ACT_ADD, 16'd2, 1, 0);
      issue(ACT_ADD, 16'd0, 1, 1);
      issue(ACT_BUILD, 16'hFFFF, 1, 1);
      issue(ACT_SEARCH, 16'd2, 0, 1);
      issue(ACT_SEARCH, 16'd1, 0, 0);
      issue(ACT_SEARCH, 16'd2, 0, 0);
      issue(ACT_SEARCH, 16'd1, 1, 0);
      issue(ACT_SEARCH, 16'd2, 0, 0);
      issue(ACT_SEARCH, 16'hFFFF, 0, 0);
      issue(ACT_SEARCH, 16'd0, 0, 1);
      issue(ACT_ADD, 16'd3, 0, 0);
      issue(ACT_SEARCH, 16'd1, 0, 0);

      // The open pattern runs two symbols past the depth limit, then discarded symbols.
      for (int i = 0; i < 33; i++) issue(ACT_ADD, 16'h5A5A, 0, 0);
      issue(ACT_ADD, 16'd1, 0, 0);
      issue(ACT_ADD, 16'd2, 1, 0);

      for (int round = 0; sent < 270; round++) begin
         if (nodes < 70)
            repeat ($urandom_range(1, 3)) begin
               len = $urandom_range(1, 4);
               for (int i = 0; i < len; i++)
                  issue(ACT_ADD, text_symbol(), i == len - 1, 1'($urandom));
            end
         if ($urandom_range(0, 3) == 0) issue(ACT_SEARCH, text_symbol(), 1'($urandom), 0);
         if (round % 3 == 0) begin
            start <= 0;
            wait (pending == 0);
            @(negedge clock);
         end
         issue(ACT_BUILD, 16'($urandom), 1'($urandom), 1'($urandom));
         repeat ($urandom_range(20, 40)) begin
            if ($urandom_range(0, 19) == 0)
               issue(2'd3, 16'($urandom), 1'($urandom), 1'($urandom));
            else
               issue(ACT_SEARCH, text_symbol(), 1'($urandom), $urandom_range(0, 9) == 0);
         end
      end

      // Closing words back to back, with no idle cycles.
      gaps_on = 0;
      fresh = 16'h1000;
      issue(ACT_ADD, fresh, 0, 0);
      issue(ACT_ADD, fresh + 16'd1, 0, 0);
      issue(ACT_ADD, fresh + 16'd2, 1, 0);
      issue(ACT_SEARCH, 16'd1, 0, 0);
      issue(2'd3, 16'd0, 0, 0);

      start <= 0;
      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("multi_pattern_symbol_matcher verification clean");
      else
         $display("multi_pattern_symbol_matcher verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mpsm_pkg.sv
rtl/mpsm_ram.sv
rtl/multi_pattern_symbol_matcher.sv
tb/mpsm_checker.sv
tb/testbench.sv
